>>> rtl/sbtr_pkg.sv
// Package for the scanned button toggle relay block.
// Holds the beat payload types, the toggle event type and register indexes.
// No dependencies.
`default_nettype none

package sbtr_pkg;

   localparam int unsigned MaxChannels = 8;
   localparam int unsigned ChanWidth   = 3;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BLOCK_ENABLE   = 2'd0,
      CSR_BUTTON_MASK    = 2'd1,
      CSR_SCAN_INTERVAL  = 2'd2,
      CSR_LOCKOUT        = 2'd3
   } sbtr_csr_idx_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [7:0]  button_levels;
   } sbtr_req_type;

   typedef struct packed {
      logic [7:0]           relay_states;
      logic                 toggle_valid;
      logic [ChanWidth-1:0] toggle_channel;
      logic                 scan_active;
   } sbtr_rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [ChanWidth-1:0] channel;
   } sbtr_toggle_type;

endpackage

`default_nettype wire

>>> rtl/sbtr_lockout.sv
// Per-channel lockout flags and start times with expiry compares.
// Depends on sbtr_pkg.
`default_nettype none

module sbtr_lockout
   import sbtr_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            enable,
   input  wire logic [31:0]     now_ms,
   input  wire logic [15:0]     lockout_ms,
   input  wire sbtr_toggle_type toggle,
   output logic [7:0]           flags_cleared
);

   logic [7:0]  flags_ff;
   logic [7:0]  flags_in;
   logic [31:0] start_ff [CHANNELS];

   for (genvar i = 0; i < MaxChannels; i++) begin : g_chan
      if (i < CHANNELS) begin : g_used
         logic [31:0] age;
         logic        expired;
         assign age     = now_ms - start_ff[i];
         assign expired = age >= {16'd0, lockout_ms};
         assign flags_cleared[i] = flags_ff[i] & ~(enable & expired);
         assign flags_in[i] = flags_cleared[i] |
                              (toggle.valid && toggle.channel == ChanWidth'(i));
      end else begin : g_unused
         assign flags_cleared[i] = 1'b0;
         assign flags_in[i]      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int unsigned j = 0; j < CHANNELS; j++) begin
         if (advance && toggle.valid && toggle.channel == ChanWidth'(j)) begin
            start_ff[j] <= now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sbtr_scan.sv
// Scan sequencer, relay state: examines a channel per scan pass, may toggle it.
// Depends on sbtr_pkg.
`default_nettype none

module sbtr_scan
   import sbtr_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            enable,
   input  wire logic [31:0]     now_ms,
   input  wire logic [7:0]      button_levels,
   input  wire logic [7:0]      button_mask,
   input  wire logic [15:0]     scan_interval_ms,
   input  wire logic [7:0]      flags_cleared,
   output sbtr_toggle_type      toggle,
   output logic [7:0]           relay_in,
   output logic                 scanning_in
);

   localparam logic [7:0] ChanMask = 8'((16'd1 << CHANNELS) - 16'd1);
   localparam logic [ChanWidth-1:0] LastChan = ChanWidth'(CHANNELS - 1);

   logic [7:0]           relay_ff;
   logic                 scanning_ff;
   logic [ChanWidth-1:0] chan_ff;
   logic [ChanWidth-1:0] chan_in;
   logic [31:0]          idle_start_ff;
   logic [31:0]          idle_start_in;
   logic                 hit;
   logic                 last;
   logic [31:0]          idle_age;

   always_comb begin
      last     = chan_ff >= LastChan;
      idle_age = now_ms - idle_start_ff;
      hit = enable && scanning_ff && (button_mask[chan_ff] & ChanMask[chan_ff]) &&
            !button_levels[chan_ff] && !flags_cleared[chan_ff];
      toggle.valid   = hit;
      toggle.channel = hit ? chan_ff : '0;
      relay_in = (relay_ff ^ (hit ? (8'd1 << chan_ff) : 8'd0)) & ChanMask;
      scanning_in   = scanning_ff;
      chan_in       = chan_ff;
      idle_start_in = idle_start_ff;
      if (enable) begin
         if (scanning_ff) begin
            if (last) begin
               scanning_in   = 1'b0;
               chan_in       = '0;
               idle_start_in = now_ms;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end else if (idle_age >= {16'd0, scan_interval_ms}) begin
            scanning_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff      <= '0;
         scanning_ff   <= 1'b0;
         chan_ff       <= '0;
         idle_start_ff <= '0;
      end else if (advance) begin
         relay_ff      <= relay_in;
         scanning_ff   <= scanning_in;
         chan_ff       <= chan_in;
         idle_start_ff <= idle_start_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/scanned_button_toggle_relays_core.sv
// Push button relay bank: control registers, input and result beat registers.
// Depends on sbtr_pkg, sbtr_lockout and sbtr_scan.
//
// Each req beat is one controller pass (millisecond time, active-low buttons);
// each pass yields exactly one rsp beat with the relay states, any toggle
// event (a save request) and the scan flag. Passes leave in arrival order.
// The pass sits in the input register while the lockout compares and scan
// step run, and its result is registered into the rsp register when it
// advances. One beat is accepted every cycle while the rsp register is free
// or being taken; a rsp beat waiting on rsp_ready does not block the next req
// beat from entering the input register. If rsp_ready stays low, the input
// register fills and req_ready drops until the result beat is taken; nothing
// is lost or repeated. Reset clears all relays, lockouts and the scan,
// disables the block and loads the default intervals (scan 100 ms, lockout
// 500 ms). Control registers are written through csr_we/csr_index/csr_wdata;
// the user must write them only while idle, the block does not enforce it.
`default_nettype none

module scanned_button_toggle_relays_core
   import sbtr_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire sbtr_req_type            req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output sbtr_rsp_type                 rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   logic         enable_ff;
   logic [7:0]   mask_ff;
   logic [15:0]  scan_interval_ff;
   logic [15:0]  lockout_ff;

   logic         in_valid_ff;
   sbtr_req_type in_data_ff;
   logic         rsp_valid_ff;
   sbtr_rsp_type rsp_data_ff;
   sbtr_rsp_type rsp_data_in;
   logic         advance;

   sbtr_toggle_type toggle;
   logic [7:0]      flags_cleared;
   logic [7:0]      relay_in;
   logic            scanning_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         mask_ff          <= '0;
         scan_interval_ff <= 16'd100;
         lockout_ff       <= 16'd500;
      end else if (csr_we) begin
         case (sbtr_csr_idx_type'(csr_index))
            CSR_BLOCK_ENABLE:  enable_ff        <= csr_wdata[0];
            CSR_BUTTON_MASK:   mask_ff          <= csr_wdata[7:0];
            CSR_SCAN_INTERVAL: scan_interval_ff <= csr_wdata;
            CSR_LOCKOUT:       lockout_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   sbtr_lockout #(
      .CHANNELS (CHANNELS)
   ) u_lockout (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .enable        (enable_ff),
      .now_ms        (in_data_ff.now_ms),
      .lockout_ms    (lockout_ff),
      .toggle        (toggle),
      .flags_cleared (flags_cleared)
   );

   sbtr_scan #(
      .CHANNELS (CHANNELS)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .enable           (enable_ff),
      .now_ms           (in_data_ff.now_ms),
      .button_levels    (in_data_ff.button_levels),
      .button_mask      (mask_ff),
      .scan_interval_ms (scan_interval_ff),
      .flags_cleared    (flags_cleared),
      .toggle           (toggle),
      .relay_in         (relay_in),
      .scanning_in      (scanning_in)
   );

   always_comb begin
      rsp_data_in.relay_states   = relay_in;
      rsp_data_in.toggle_valid   = toggle.valid;
      rsp_data_in.toggle_channel = toggle.channel;
      rsp_data_in.scan_active    = scanning_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> tb/sv/scanned_button_toggle_relays_core_tb.sv
// Self-checking bench for scanned_button_toggle_relays_core: directed passes, then random phases.
// Drives req/rsp beats with random gaps and a receiver hold-off, and checks each rsp beat
// against an in-bench relay bank predictor. Depends on sbtr_pkg and the core RTL.
module scanned_button_toggle_relays_core_tb;
   import sbtr_pkg::*;

   localparam int unsigned LastChan = MaxChannels - 1;

   localparam sbtr_rsp_type RspQuiet     = '0;
   localparam sbtr_rsp_type RspScanStart = '{8'h00, 1'b0, 3'd0, 1'b1};

   typedef struct packed {
      logic             is_reg;
      sbtr_csr_idx_type reg_idx;
      logic [15:0]      reg_val;
      logic [31:0]      now_ms;
      logic [7:0]       levels;
      logic             typed;
      sbtr_rsp_type     want;
   } stim_row_type;

   localparam int unsigned DirRows = 26;

   stim_row_type directed [DirRows] = '{
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'h0000_0000, 8'hFF, 1'b1, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'hFFFF_FFFF, 8'h00, 1'b1, RspQuiet},
      '{1'b1, CSR_BLOCK_ENABLE,  16'h0001, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b1, CSR_BUTTON_MASK,   16'h00FF, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b1, CSR_SCAN_INTERVAL, 16'h0000, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b1, CSR_LOCKOUT,       16'h0000, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd10, 8'hFF, 1'b1, RspScanStart},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd11, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd12, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd13, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd14, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd15, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd16, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd17, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd18, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd20, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'd21, 8'h00, 1'b0, RspQuiet},
      '{1'b1, CSR_LOCKOUT,       16'hFFFF, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b1, CSR_SCAN_INTERVAL, 16'hFFFF, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b1, CSR_BUTTON_MASK,   16'h005A, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'hFFFF_FFF0, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'h0000_0005, 8'hAA, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'h8000_0000, 8'h55, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'h7FFF_FFFF, 8'h00, 1'b0, RspQuiet},
      '{1'b1, CSR_BLOCK_ENABLE,  16'h0000, 32'h0, 8'h00, 1'b0, RspQuiet},
      '{1'b0, CSR_BLOCK_ENABLE,  16'h0000, 32'h0000_1234, 8'h00, 1'b0, RspQuiet}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sbtr_req_type     req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sbtr_rsp_type     rsp_data;
   logic             csr_we = 1'b0;
   sbtr_csr_idx_type csr_index = CSR_BLOCK_ENABLE;
   logic [15:0]      csr_wdata = '0;

   // relay bank model state and its copy of the control registers
   logic [7:0]  relay_model = '0;
   logic [7:0]  locked = '0;
   logic [31:0] lock_stamp [MaxChannels];
   logic        scan_on = 1'b0;
   logic [2:0]  scan_pos = '0;
   logic [31:0] idle_stamp = '0;
   logic        cfg_enable = 1'b0;
   logic [7:0]  cfg_mask = '0;
   logic [15:0] cfg_scan_ms = 16'd100;
   logic [15:0] cfg_lock_ms = 16'd500;

   sbtr_rsp_type owed_states [$];
   int unsigned  mismatches = 0;
   int unsigned  rx_hold = 0;
   int unsigned  rx_beats = 0;
   logic         tx_quiet = 1'b0;

   scanned_button_toggle_relays_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #(20 * 200000);
      $display("scanned_button_toggle_relays_core_tb: errors");
      $finish;
   end

   function automatic sbtr_rsp_type step_relay_bank(sbtr_req_type pass);
      sbtr_rsp_type r;
      logic [2:0]   ch;
      logic [31:0]  age;
      int           i;
      r = '0;
      if (cfg_enable) begin
         for (i = 0; i < MaxChannels; i++) begin
            age = pass.now_ms - lock_stamp[i];
            if (locked[i] && age >= {16'd0, cfg_lock_ms})
               locked[i] = 1'b0;
         end
         if (scan_on) begin
            ch = scan_pos;
            if (cfg_mask[ch] && !pass.button_levels[ch] && !locked[ch]) begin
               relay_model[ch] = ~relay_model[ch];
               locked[ch] = 1'b1;
               lock_stamp[ch] = pass.now_ms;
               r.toggle_valid = 1'b1;
               r.toggle_channel = ch;
            end
            if (ch == 3'(LastChan)) begin
               scan_on = 1'b0;
               idle_stamp = pass.now_ms;
               scan_pos = '0;
            end else begin
               scan_pos = ch + 3'd1;
            end
         end else begin
            age = pass.now_ms - idle_stamp;
            if (age >= {16'd0, cfg_scan_ms})
               scan_on = 1'b1;
         end
      end
      r.relay_states = relay_model;
      r.scan_active = scan_on;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // drop valid, wait out every owed beat, then the pipeline latency
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_states.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(sbtr_csr_idx_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BLOCK_ENABLE:  cfg_enable = val[0];
         CSR_BUTTON_MASK:   cfg_mask = val[7:0];
         CSR_SCAN_INTERVAL: cfg_scan_ms = val;
         CSR_LOCKOUT:       cfg_lock_ms = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_pass(sbtr_req_type pass, logic typed, sbtr_rsp_type want);
      int unsigned  gap;
      sbtr_rsp_type predicted;
      gap = tx_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= pass;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_relay_bank(pass);
      owed_states.insert(owed_states.size(), typed ? want : predicted);
   endtask

   initial begin : rsp_side
      int unsigned  gap;
      sbtr_rsp_type want;
      wait (!reset);
      forever begin
         if (rx_hold > 0) begin
            gap = rx_hold;
            rx_hold = 0;
         end else begin
            gap = (((rx_beats / 32) % 4) == 3) ? 0 : $urandom_range(0, 18);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rx_beats++;
         if (owed_states.size() == 0) begin
            flag_mismatch("unexpected beat", 32'(rsp_data), '0);
         end else begin
            want = owed_states.pop_front();
            if (rsp_data.relay_states !== want.relay_states)
               flag_mismatch("relay_states", 32'(rsp_data.relay_states),
                             32'(want.relay_states));
            if (rsp_data.toggle_valid !== want.toggle_valid)
               flag_mismatch("toggle_valid", 32'(rsp_data.toggle_valid),
                             32'(want.toggle_valid));
            if (rsp_data.toggle_channel !== want.toggle_channel)
               flag_mismatch("toggle_channel", 32'(rsp_data.toggle_channel),
                             32'(want.toggle_channel));
            if (rsp_data.scan_active !== want.scan_active)
               flag_mismatch("scan_active", 32'(rsp_data.scan_active),
                             32'(want.scan_active));
         end
      end
   end

   initial begin : req_side
      int unsigned  ph;
      int unsigned  k;
      int unsigned  pick;
      logic [31:0]  t;
      logic [15:0]  en, mask, scan_ms, lock_ms;
      sbtr_req_type pass;
      for (int c = 0; c < MaxChannels; c++) lock_stamp[c] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DirRows; k++) begin
         if (directed[k].is_reg) begin
            settle();
            write_reg(directed[k].reg_idx, directed[k].reg_val);
         end else begin
            pass.now_ms = directed[k].now_ms;
            pass.button_levels = directed[k].levels;
            send_pass(pass, directed[k].typed, directed[k].want);
         end
      end

      for (ph = 0; ph < 8; ph++) begin
         en = 16'd1;
         mask = 16'($urandom_range(1, 255));
         scan_ms = 16'($urandom_range(0, 300));
         lock_ms = 16'($urandom_range(0, 800));
         case (ph)
            0: begin mask = 16'h00FF; scan_ms = 16'h0000; lock_ms = 16'h0000; end
            1: begin mask = 16'h00FF; scan_ms = 16'hFFFF; lock_ms = 16'hFFFF; end
            2: en = 16'd0;
            6: mask = 16'h0000;
            default: ;
         endcase
         settle();
         write_reg(CSR_BLOCK_ENABLE, en);
         write_reg(CSR_BUTTON_MASK, mask);
         write_reg(CSR_SCAN_INTERVAL, scan_ms);
         write_reg(CSR_LOCKOUT, lock_ms);
         t = (ph == 5) ? 32'hFFFF_F000 : $urandom;
         tx_quiet = (ph == 4);
         for (k = 0; k < 50; k++) begin
            if (ph == 3 && k == 10) begin
               rx_hold = 80;
               tx_quiet = 1'b1;
            end
            if (ph == 3 && k == 40) tx_quiet = 1'b0;
            if (ph == 5 && k == 25) settle();
            pick = $urandom_range(0, 99);
            if (pick < 60)      t = t + $urandom_range(0, 15);
            else if (pick < 85) t = t + $urandom_range(0, 150);
            else if (pick < 93) t = $urandom;
            else                t = t + $urandom_range(0, 70000);
            pass.now_ms = t;
            pass.button_levels = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom & $urandom);
            send_pass(pass, 1'b0, RspQuiet);
         end
      end

      settle();
      if (mismatches == 0)
         $display("scanned_button_toggle_relays_core_tb: clean");
      else
         $display("scanned_button_toggle_relays_core_tb: errors");
      $finish;
   end

endmodule
